// File: rtl/slpb_pkg.sv
// ----------------------------------------------------------------------------
// slpb_pkg
// Shared types and constants of the status lamp priority blinker.
// ----------------------------------------------------------------------------
package slpb_pkg;

  // Condition codes, in priority order.
  typedef enum logic [2:0] {
    COND_OFF      = 3'd0,
    COND_ALARM    = 3'd1,
    COND_CHARGING = 3'd2,
    COND_CHARGED  = 3'd3,
    COND_LOW      = 3'd4,
    COND_NOFIX    = 3'd5,
    COND_ALIVE    = 3'd6
  } cond_t;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_ALARM_THRESHOLD  = 3'd0,
    REG_CADENCE_OFF      = 3'd1,
    REG_CADENCE_ALARM    = 3'd2,
    REG_CADENCE_CHARGING = 3'd3,
    REG_CADENCE_CHARGED  = 3'd4,
    REG_CADENCE_LOW      = 3'd5,
    REG_CADENCE_NOFIX    = 3'd6,
    REG_CADENCE_ALIVE    = 3'd7
  } reg_idx_t;

  // Lamp colour codes.
  typedef enum logic [1:0] {
    LAMP_DARK  = 2'd0,
    LAMP_GREEN = 2'd1,
    LAMP_RED   = 2'd2,
    LAMP_BLUE  = 2'd3
  } lamp_t;

  localparam int NUM_COND       = 7;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_ADDR_W     = 6;
  localparam int TIME_W         = 32;
  localparam int PHASE_W        = 16;
  localparam int QUEUE_DEPTH    = 2;
  localparam logic [7:0] ALARM_THRESHOLD_RST = 8'd1;

  // One cadence register: colour, on time and off time in ms.
  typedef struct packed {
    logic [1:0]         colour;
    logic [PHASE_W-1:0] on_ms;
    logic [PHASE_W-1:0] off_ms;
  } cadence_t;

  localparam int CADENCE_W = $bits(cadence_t);

  // A classified update pass, passed from the front to the back.
  typedef struct packed {
    cond_t             cond;
    logic [TIME_W-1:0] now_ms;
  } front_item_t;

endpackage

// File: rtl/slpb_if.sv
// ----------------------------------------------------------------------------
// slpb_if
// Valid/ready channels of the status lamp priority blinker.
// ----------------------------------------------------------------------------

// Update pass channel.
interface slpb_in_if;
  logic        valid;
  logic        ready;
  logic        running;
  logic [7:0]  alert_sev;
  logic        ext_supply;
  logic        batt_full;
  logic        power_low;
  logic        pos_locked;
  logic [31:0] now_ms;

  modport source (
    output valid, running, alert_sev, ext_supply, batt_full,
           power_low, pos_locked, now_ms,
    input  ready
  );
  modport sink (
    input  valid, running, alert_sev, ext_supply, batt_full,
           power_low, pos_locked, now_ms,
    output ready
  );
endinterface

// Lamp result channel.
interface slpb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] lamp;
  logic       changed;

  modport source (
    output valid, lamp, changed,
    input  ready
  );
  modport sink (
    input  valid, lamp, changed,
    output ready
  );
endinterface

// File: rtl/slpb_front.sv
// ----------------------------------------------------------------------------
// slpb_front
// Accepts update passes, picks the condition by priority and registers it.
// ----------------------------------------------------------------------------
module slpb_front
  import slpb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  slpb_in_if.sink          in_bus,
  input  logic [7:0]       alarm_threshold,
  output logic             item_valid,
  input  logic             item_ready,
  output front_item_t      item_data
);

  logic        valid_r;
  logic        valid_nxt;
  front_item_t data_r;
  cond_t       wanted;
  logic        take;

  // Fixed priority: off, alarm, external power, low power, then fix state.
  always_comb begin
    if (!in_bus.running) begin
      wanted = COND_OFF;
    end else if (in_bus.alert_sev >= alarm_threshold) begin
      wanted = COND_ALARM;
    end else if (in_bus.ext_supply) begin
      wanted = in_bus.batt_full ? COND_CHARGED : COND_CHARGING;
    end else if (in_bus.power_low) begin
      wanted = COND_LOW;
    end else begin
      wanted = in_bus.pos_locked ? COND_ALIVE : COND_NOFIX;
    end
  end

  // The stage takes a new request when empty or when its item moves on.
  assign in_bus.ready = !valid_r || item_ready;
  assign take         = in_bus.valid && in_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (item_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register, loaded on every accepted request.
  always_ff @(posedge clk) begin
    if (take) begin
      data_r.cond   <= wanted;
      data_r.now_ms <= in_bus.now_ms;
    end
  end

  assign item_valid = valid_r;
  assign item_data  = data_r;

endmodule

// File: rtl/slpb_queue.sv
// ----------------------------------------------------------------------------
// slpb_queue
// Short register queue between the classifier and the cadence engine.
// ----------------------------------------------------------------------------
module slpb_queue
  import slpb_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  front_item_t push_data,
  output logic        pop_valid,
  input  logic        pop_ready,
  output front_item_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  front_item_t       entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push, pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entry_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/slpb_back.sv
// ----------------------------------------------------------------------------
// slpb_back
// Cadence engine: tracks the condition and blink phase, registers the lamp.
// ----------------------------------------------------------------------------
module slpb_back
  import slpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  output logic        item_ready,
  input  front_item_t item_data,
  input  cadence_t    cadence [NUM_COND],
  slpb_out_if.source  out_bus
);

  cond_t             cur_cond_r, cur_cond_nxt;
  logic              started_r, started_nxt;
  logic [TIME_W-1:0] phase_start_r, phase_start_nxt;
  logic              lit_r, lit_nxt;
  logic [1:0]        shown_r, shown_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_lamp_r;
  logic              out_changed_r;

  cadence_t          cad_want, cad_cur;
  logic              restart;
  logic              pop;
  logic [PHASE_W:0]  cycle_len;
  logic [TIME_W-1:0] elapsed;
  logic [PHASE_W-1:0] phase_len;
  logic [1:0]        lamp_val;

  // Cadence lookup for a condition code.
  function automatic cadence_t pick_cadence(cond_t c, cadence_t cad [NUM_COND]);
    cadence_t r;
    case (c)
      COND_OFF:      r = cad[0];
      COND_ALARM:    r = cad[1];
      COND_CHARGING: r = cad[2];
      COND_CHARGED:  r = cad[3];
      COND_LOW:      r = cad[4];
      COND_NOFIX:    r = cad[5];
      COND_ALIVE:    r = cad[6];
      default:       r = '0;
    endcase
    return r;
  endfunction

  assign cad_want = pick_cadence(item_data.cond, cadence);
  assign cad_cur  = pick_cadence(cur_cond_r, cadence);

  // The output register frees up when its result is taken.
  assign item_ready = !out_valid_r || out_bus.ready;
  assign pop        = item_valid && item_ready;

  assign restart   = (item_data.cond != cur_cond_r) || !started_r;
  assign cycle_len = {1'b0, cad_cur.on_ms} + {1'b0, cad_cur.off_ms};
  assign elapsed   = item_data.now_ms - phase_start_r;
  assign phase_len = lit_r ? cad_cur.on_ms : cad_cur.off_ms;

  // Next blink state for the popped pass.
  always_comb begin
    cur_cond_nxt    = cur_cond_r;
    started_nxt     = started_r;
    phase_start_nxt = phase_start_r;
    lit_nxt         = lit_r;
    if (restart) begin
      cur_cond_nxt    = item_data.cond;
      started_nxt     = 1'b1;
      phase_start_nxt = item_data.now_ms;
      lit_nxt         = cad_want.colour != LAMP_DARK;
    end else if (cad_cur.colour == LAMP_DARK || cad_cur.on_ms == '0) begin
      lit_nxt = 1'b0;
    end else if (cad_cur.off_ms == '0) begin
      lit_nxt = 1'b1;
    end else if (elapsed >= TIME_W'(cycle_len)) begin
      // A late pass restarts the flash.
      phase_start_nxt = item_data.now_ms;
      lit_nxt         = 1'b1;
    end else if (elapsed >= TIME_W'(phase_len)) begin
      phase_start_nxt = phase_start_r + TIME_W'(phase_len);
      lit_nxt         = !lit_r;
    end
  end

  always_comb begin
    if (!lit_nxt) begin
      lamp_val = LAMP_DARK;
    end else if (restart) begin
      lamp_val = cad_want.colour;
    end else begin
      lamp_val = cad_cur.colour;
    end
  end

  assign shown_nxt = pop ? lamp_val : shown_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state advances only on a popped pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_cond_r    <= COND_OFF;
      started_r     <= 1'b0;
      phase_start_r <= '0;
      lit_r         <= 1'b0;
      shown_r       <= LAMP_DARK;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      shown_r     <= shown_nxt;
      if (pop) begin
        cur_cond_r    <= cur_cond_nxt;
        started_r     <= started_nxt;
        phase_start_r <= phase_start_nxt;
        lit_r         <= lit_nxt;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_lamp_r    <= lamp_val;
      out_changed_r <= lamp_val != shown_r;
    end
  end

  assign out_bus.valid   = out_valid_r;
  assign out_bus.lamp    = out_lamp_r;
  assign out_bus.changed = out_changed_r;

endmodule

// File: rtl/status_lamp_priority_blinker.sv
// ----------------------------------------------------------------------------
// status_lamp_priority_blinker
// Picks a lamp condition from system flags and blinks its cadence.
//
//   Channel   Direction  Handshake         Payload
//   in_bus    sink       valid/ready       flags, alert_sev, now_ms
//   out_bus   source     valid/ready       lamp, changed
//   APB       slave      psel/penable      8 registers, 64-bit data, 8*i
//
// One request is taken every cycle while out_bus keeps taking results; its
// result passes the classifier register, then the queue, then the output
// register before out_bus can take it.
// The cadence engine keeps all blink state in flip-flops and updates condition,
// phase start and lit bit on each popped pass, so it pops again once out_bus takes.
// Reset is synchronous; no clearing pass is needed and in_bus is ready at once.
// A stalled output holds the result register, the queue fills, then the input
// stalls; once out_bus is taken the queue frees an entry and the input resumes.
// ----------------------------------------------------------------------------
module status_lamp_priority_blinker
  import slpb_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  slpb_in_if.sink               in_bus,
  slpb_out_if.source            out_bus,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [7:0]  alarm_threshold_r;
  cadence_t    cadence_r [NUM_COND];
  reg_idx_t    reg_idx;
  logic        cfg_write;

  logic        front_valid, front_ready;
  front_item_t front_data;
  logic        back_valid, back_ready;
  front_item_t back_data;

  // Register file: register i lives at byte address 8*i.
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[5:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_threshold_r <= ALARM_THRESHOLD_RST;
      for (int i = 0; i < NUM_COND; i++) begin
        cadence_r[i] <= '0;
      end
    end else if (cfg_write) begin
      case (reg_idx)
        REG_ALARM_THRESHOLD:  alarm_threshold_r <= pwdata[7:0];
        REG_CADENCE_OFF:      cadence_r[0] <= pwdata[CADENCE_W-1:0];
        REG_CADENCE_ALARM:    cadence_r[1] <= pwdata[CADENCE_W-1:0];
        REG_CADENCE_CHARGING: cadence_r[2] <= pwdata[CADENCE_W-1:0];
        REG_CADENCE_CHARGED:  cadence_r[3] <= pwdata[CADENCE_W-1:0];
        REG_CADENCE_LOW:      cadence_r[4] <= pwdata[CADENCE_W-1:0];
        REG_CADENCE_NOFIX:    cadence_r[5] <= pwdata[CADENCE_W-1:0];
        REG_CADENCE_ALIVE:    cadence_r[6] <= pwdata[CADENCE_W-1:0];
        default:              alarm_threshold_r <= alarm_threshold_r;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_idx)
      REG_ALARM_THRESHOLD:  prdata = CFG_DATA_W'(alarm_threshold_r);
      REG_CADENCE_OFF:      prdata = CFG_DATA_W'(cadence_r[0]);
      REG_CADENCE_ALARM:    prdata = CFG_DATA_W'(cadence_r[1]);
      REG_CADENCE_CHARGING: prdata = CFG_DATA_W'(cadence_r[2]);
      REG_CADENCE_CHARGED:  prdata = CFG_DATA_W'(cadence_r[3]);
      REG_CADENCE_LOW:      prdata = CFG_DATA_W'(cadence_r[4]);
      REG_CADENCE_NOFIX:    prdata = CFG_DATA_W'(cadence_r[5]);
      REG_CADENCE_ALIVE:    prdata = CFG_DATA_W'(cadence_r[6]);
      default:              prdata = '0;
    endcase
  end

  // Classifier.
  slpb_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_bus          (in_bus),
    .alarm_threshold (alarm_threshold_r),
    .item_valid      (front_valid),
    .item_ready      (front_ready),
    .item_data       (front_data)
  );

  // Queue between classifier and cadence engine.
  slpb_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_data),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_data)
  );

  // Cadence engine and result register.
  slpb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (back_valid),
    .item_ready (back_ready),
    .item_data  (back_data),
    .cadence    (cadence_r),
    .out_bus    (out_bus)
  );

endmodule

// File: dv/tb_status_lamp_priority_blinker.sv
// ----------------------------------------------------------------------------
// tb_status_lamp_priority_blinker
// Self-checking testbench of the status lamp priority blinker.
// A behavioral lamp predictor runs next to the block and is updated at each
// accepted update request. Every lamp result is checked, field by field,
// against the oldest predicted one. Directed passes cover the condition
// priority and the blink corner cases. Random phases use sequences of steady
// flags with advancing time, under changing cadence settings and handshake
// idling. A pressure test stalls the result side until the input backs up.
// ----------------------------------------------------------------------------
module tb_status_lamp_priority_blinker;
  import slpb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One update request as the sender presents it.
  typedef struct packed {
    logic        running;
    logic [7:0]  alert_sev;
    logic        ext_supply;
    logic        batt_full;
    logic        power_low;
    logic        pos_locked;
    logic [31:0] now_ms;
  } update_t;

  localparam int UPD_W = $bits(update_t);

  // One predicted lamp result.
  typedef struct packed {
    lamp_t lamp;
    logic  changed;
  } lamp_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  slpb_in_if  in_bus ();
  slpb_out_if out_bus ();

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  status_lamp_priority_blinker u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // Predictor copy of the configuration and of the blink state.
  logic [7:0] alarm_thr;
  cadence_t   cadence_cfg [NUM_COND];
  cond_t      cur_cond;
  logic       started;
  logic [31:0] phase_start;
  logic       lit;
  lamp_t      shown_lamp;

  lamp_rsp_t pending_lamps [$];
  int        fail_count;

  // Handshake idling and the long result stall.
  int snd_idle_pct;
  int rcv_idle_pct;
  int hold_req;
  int hold_seen;
  int hold_left;

  // Random sequence state: steady flags held over a run of passes.
  logic [31:0] clock_ms;
  update_t     seq_flags;
  int          run_left;
  int          step_max;

  // Works out the lamp result of one accepted update and queues it.
  function automatic void predict_lamp(update_t u);
    cond_t       want;
    cadence_t    cd;
    logic [31:0] cycle_ms;
    logic [31:0] elapsed;
    logic [31:0] len;
    lamp_rsp_t   r;
    if (!u.running) want = COND_OFF;
    else if (u.alert_sev >= alarm_thr) want = COND_ALARM;
    else if (u.ext_supply) want = u.batt_full ? COND_CHARGED : COND_CHARGING;
    else if (u.power_low) want = COND_LOW;
    else want = u.pos_locked ? COND_ALIVE : COND_NOFIX;

    if (want != cur_cond || !started) begin
      // A new condition restarts its cadence, lit unless the colour is dark.
      cur_cond    = want;
      started     = 1'b1;
      phase_start = u.now_ms;
      lit         = (cadence_cfg[want].colour != LAMP_DARK);
    end else begin
      cd = cadence_cfg[cur_cond];
      if (cd.colour == LAMP_DARK || cd.on_ms == '0) begin
        lit = 1'b0;
      end else if (cd.off_ms == '0) begin
        lit = 1'b1;
      end else begin
        cycle_ms = 32'(cd.on_ms) + 32'(cd.off_ms);
        elapsed  = u.now_ms - phase_start;
        if (elapsed >= cycle_ms) begin
          // A pass a full cycle late restarts the flash.
          phase_start = u.now_ms;
          lit         = 1'b1;
        end else begin
          len = lit ? 32'(cd.on_ms) : 32'(cd.off_ms);
          if (elapsed >= len) begin
            phase_start = phase_start + len;
            lit         = !lit;
          end
        end
      end
    end

    r.lamp    = lit ? lamp_t'(cadence_cfg[cur_cond].colour) : LAMP_DARK;
    r.changed = (r.lamp != shown_lamp);
    shown_lamp = r.lamp;
    pending_lamps.push_back(r);
  endfunction

  function automatic update_t make_update(logic run, logic [7:0] level, logic ext,
                                          logic full, logic low, logic fix,
                                          logic [31:0] now);
    update_t u;
    u.running    = run;
    u.alert_sev  = level;
    u.ext_supply = ext;
    u.batt_full  = full;
    u.power_low  = low;
    u.pos_locked = fix;
    u.now_ms     = now;
    return u;
  endfunction

  // Next random update: mostly steady flags with time moving forward,
  // with some noise passes and large time jumps.
  function automatic update_t next_update();
    update_t u;
    if (run_left == 0) begin
      run_left  = $urandom_range(1, 24);
      seq_flags = update_t'(UPD_W'({$urandom, $urandom}));
      seq_flags.running = ($urandom_range(9) != 0);
      case ($urandom_range(3))
        0: step_max = 2;
        1: step_max = 8;
        2: step_max = 30;
        default: step_max = 70;
      endcase
    end
    run_left--;
    u = seq_flags;
    if ($urandom_range(99) < 10) begin
      u = update_t'(UPD_W'({$urandom, $urandom}));
      clock_ms = $urandom;
    end else if ($urandom_range(99) < 3) begin
      clock_ms = clock_ms + $urandom;
    end else begin
      clock_ms = clock_ms + $urandom_range(0, step_max);
    end
    u.now_ms = clock_ms;
    return u;
  endfunction

  function automatic logic [15:0] random_ms();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 25));
    endcase
  endfunction

  // Cadence value with junk in the unused upper bits.
  function automatic logic [63:0] random_cadence();
    cadence_t c;
    c.colour = 2'($urandom);
    c.on_ms  = random_ms();
    c.off_ms = random_ms();
    return {30'($urandom), c};
  endfunction

  // Register write: setup cycle, access cycle, then the bus goes idle.
  task automatic apb_write(input reg_idx_t idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ALARM_THRESHOLD) alarm_thr = value[7:0];
    else cadence_cfg[idx - REG_CADENCE_OFF] = cadence_t'(value[CADENCE_W-1:0]);
    @(posedge clk);
  endtask

  task automatic set_cadence(input reg_idx_t idx, input lamp_t colour,
                             input logic [15:0] on_ms, input logic [15:0] off_ms);
    apb_write(idx, {30'd0, colour, on_ms, off_ms});
  endtask

  // Sends one update request and predicts its result once it is accepted.
  task automatic send_update(input update_t u);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.running    <= u.running;
    in_bus.alert_sev  <= u.alert_sev;
    in_bus.ext_supply <= u.ext_supply;
    in_bus.batt_full  <= u.batt_full;
    in_bus.power_low  <= u.power_low;
    in_bus.pos_locked <= u.pos_locked;
    in_bus.now_ms     <= u.now_ms;
    do @(posedge clk); while (!in_bus.ready);
    predict_lamp(u);
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending_lamps.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic configure_random();
    case ($urandom_range(4))
      0: apb_write(REG_ALARM_THRESHOLD, {56'($urandom), 8'h00});
      1: apb_write(REG_ALARM_THRESHOLD, {56'($urandom), 8'hFF});
      2: apb_write(REG_ALARM_THRESHOLD, {56'($urandom), 8'h80});
      default: apb_write(REG_ALARM_THRESHOLD, {$urandom, $urandom});
    endcase
    for (int i = REG_CADENCE_OFF; i <= REG_CADENCE_ALIVE; i++) begin
      apb_write(reg_idx_t'(i), random_cadence());
    end
  endtask

  // With reset cadences every condition is dark.
  task automatic test_reset_defaults();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    send_update(make_update(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0));
    send_update(make_update(1'b1, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 32'd1));
    send_update(make_update(1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 32'd2));
    send_update(make_update(1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 32'd3));
    wait_drained();
  endtask

  // Priority order and blink corner cases with hand-picked cadences.
  task automatic test_directed_cadence();
    apb_write(REG_ALARM_THRESHOLD, 64'd255);
    set_cadence(REG_CADENCE_OFF,      LAMP_GREEN, 16'd3,    16'd2);
    set_cadence(REG_CADENCE_ALARM,    LAMP_RED,   16'd0,    16'd5);
    set_cadence(REG_CADENCE_CHARGING, LAMP_BLUE,  16'd4,    16'd0);
    set_cadence(REG_CADENCE_CHARGED,  LAMP_DARK,  16'd5,    16'd5);
    set_cadence(REG_CADENCE_LOW,      LAMP_GREEN, 16'hFFFF, 16'hFFFF);
    set_cadence(REG_CADENCE_NOFIX,    LAMP_RED,   16'd2,    16'd3);
    set_cadence(REG_CADENCE_ALIVE,    LAMP_BLUE,  16'd1,    16'd1);

    // Off condition: lit, phase end to dark, back to lit, then a late pass.
    send_update(make_update(1'b0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 32'd0));
    send_update(make_update(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd2));
    send_update(make_update(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd3));
    send_update(make_update(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd5));
    send_update(make_update(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd100));
    // Alarm with zero on time: lit for the restart pass only.
    send_update(make_update(1'b1, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 32'd101));
    send_update(make_update(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd102));
    // Charging with zero off time stays lit.
    send_update(make_update(1'b1, 8'hFE, 1'b1, 1'b0, 1'b1, 1'b0, 32'd103));
    send_update(make_update(1'b1, 8'hFE, 1'b1, 1'b0, 1'b0, 1'b1, 32'd5000));
    // Charged has a dark colour.
    send_update(make_update(1'b1, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 32'd5001));
    send_update(make_update(1'b1, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 32'd5002));
    // Low power with the longest phases, across the time wrap.
    send_update(make_update(1'b1, 8'h7F, 1'b0, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFF0));
    send_update(make_update(1'b1, 8'h7F, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0000_0010));
    send_update(make_update(1'b1, 8'h7F, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0001_0000));
    // No fix, then alive, blinking across another wrap.
    send_update(make_update(1'b1, 8'h01, 1'b0, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF));
    send_update(make_update(1'b1, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 32'd1));
    send_update(make_update(1'b1, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 32'd4));
    send_update(make_update(1'b1, 8'h80, 1'b0, 1'b1, 1'b0, 1'b1, 32'd10));
    send_update(make_update(1'b1, 8'h80, 1'b0, 1'b0, 1'b0, 1'b1, 32'd11));
    send_update(make_update(1'b1, 8'h80, 1'b0, 1'b0, 1'b0, 1'b1, 32'd12));
    wait_drained();

    // A zero threshold makes every running pass an alarm.
    apb_write(REG_ALARM_THRESHOLD, 64'd0);
    send_update(make_update(1'b1, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 32'd13));
    send_update(make_update(1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd14));
    wait_drained();
  endtask

  // One random phase under a fresh random configuration.
  task automatic test_random_phase(input int snd_pct, input int rcv_pct,
                                   input int count, input logic [31:0] start_ms);
    configure_random();
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    clock_ms = start_ms;
    run_left = 0;
    repeat (count) send_update(next_update());
    wait_drained();
  endtask

  // The receiver holds off while requests keep coming, so the input stalls;
  // then the sender pauses until every result is back and sends a second batch.
  task automatic test_result_backpressure();
    configure_random();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    clock_ms = $urandom;
    run_left = 0;
    hold_req++;
    repeat (20) send_update(next_update());
    wait_drained();
    repeat (20) send_update(next_update());
    wait_drained();
  endtask

  // Result side: random stalls plus the long hold-off.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Checks each accepted lamp result against the oldest prediction.
  always @(posedge clk) begin
    lamp_rsp_t exp_rsp;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_lamps.size() == 0) begin
        $error("unexpected lamp result: lamp %0d changed %0b",
               out_bus.lamp, out_bus.changed);
        fail_count++;
      end else begin
        exp_rsp = pending_lamps.pop_front();
        if (out_bus.lamp !== exp_rsp.lamp) begin
          $error("lamp mismatch: expected %0d, actual %0d", exp_rsp.lamp, out_bus.lamp);
          fail_count++;
        end
        if (out_bus.changed !== exp_rsp.changed) begin
          $error("changed mismatch: expected %0b, actual %0b",
                 exp_rsp.changed, out_bus.changed);
          fail_count++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    #400_000;
    $display("status_lamp_priority_blinker verification failed");
    $finish;
  end

  initial begin
    in_bus.valid      = 1'b0;
    in_bus.running    = 1'b0;
    in_bus.alert_sev  = '0;
    in_bus.ext_supply = 1'b0;
    in_bus.batt_full  = 1'b0;
    in_bus.power_low  = 1'b0;
    in_bus.pos_locked = 1'b0;
    in_bus.now_ms     = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    fail_count   = 0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req  = 0;
    hold_seen = 0;
    hold_left = 0;
    run_left  = 0;
    step_max  = 2;
    clock_ms  = '0;
    seq_flags = '0;

    // Predictor reset state.
    alarm_thr = ALARM_THRESHOLD_RST;
    for (int i = 0; i < NUM_COND; i++) cadence_cfg[i] = '0;
    cur_cond    = COND_OFF;
    started     = 1'b0;
    phase_start = '0;
    lit         = 1'b0;
    shown_lamp  = LAMP_DARK;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed_cadence();
    test_random_phase(36, 63, 250, 32'd0);
    test_random_phase(63, 36, 250, 32'hFFFF_FF00);
    test_random_phase(0, 0, 250, $urandom);
    test_result_backpressure();

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status_lamp_priority_blinker verification clean");
    end else begin
      $display("status_lamp_priority_blinker verification failed");
    end
    $finish;
  end

endmodule
